// ===== sv/kmi_pkg.sv =====
package kmi_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_TIME = 2'd0,
    CMD_LOAD_ELEM = 2'd1,
    CMD_EVAL      = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_e;

  localparam logic [0:0] REG_CYCLE_LENGTH = 1'b0;
  localparam logic [0:0] REG_KEY_COUNT    = 1'b1;

  localparam logic [31:0] CYCLE_LENGTH_RST = 32'd65536;
  localparam logic [4:0]  KEY_COUNT_RST    = 5'd1;

endpackage

// ===== sv/keyframe_matrix_interpolator.sv =====
// Keyframe matrix interpolator.
// Issue an item by raising start while busy is low. Command 0 stores a key
// time and command 1 stores one matrix element (key_index_i*16+element_index_i);
// both are taken at once, give no result and leave busy low, so loads can
// follow back to back. Command 2 evaluates the looping animation at now_time_i:
// the time is reduced modulo cycle_length by a bit-serial divider (skipped
// when cycle_length is zero), the key times are scanned from one synchronous
// memory, the segment length is formed, a second bit-serial divider forms the
// interpolation ratio (bypassed when the ratio is trivially 0 or 1), then the
// 16 element pairs are read from the matrix memory and blended one element at
// a time. Rows come out on result_valid_o one cycle each, rows 0..3 in order,
// last_row_o marking row 3. How long an evaluation keeps busy high is set by
// the two serial dividers and the one-read-port memories; busy falls at the
// edge that puts row 3 on the ports. The receiver cannot stall: each row is
// shown for exactly one cycle. Configuration writes (cfg_we_i, cfg_index_i,
// cfg_data_i) land at once; apply them only while the block is idle. Reset
// sets cycle_length to 65536 and key_count to 1; the memories hold anything
// until written.
module keyframe_matrix_interpolator
  import kmi_pkg::*;
#(
  parameter int MAX_KEYS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  command_i,
  input  logic [3:0]  key_index_i,
  input  logic [3:0]  element_index_i,
  input  logic signed [31:0] load_value_i,
  input  logic [31:0] now_time_i,
  output logic        result_valid_o,
  output logic [1:0]  row_index_o,
  output logic signed [31:0] col0_o,
  output logic signed [31:0] col1_o,
  output logic signed [31:0] col2_o,
  output logic signed [31:0] col3_o,
  output logic        last_row_o
);

  localparam int KW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int RW = FRAC_BITS + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_SCAN, S_SEG, S_DIV, S_ELEM, S_OUT
  } state_e;

  logic [31:0] cycle_len_q;
  logic [4:0]  key_count_q;

  logic [31:0] time_mem [MAX_KEYS];
  logic [31:0] mat_mem  [MAX_KEYS*16];
  logic [31:0] time_rd_q, mat_rd_q;
  logic [KW-1:0] time_ra;
  logic [KW+3:0] mat_ra;
  logic time_re, mat_re;

  state_e state_q;
  logic [5:0]  cnt_q;
  logic [31:0] t_q, rem_q, quo_q;
  logic [CW-1:0] idx_q, count_q;
  logic        found_q, stop_q;
  logic [KW-1:0] sel_q;
  logic [31:0] tsel_q;
  logic [32:0] el_q, seg_q;
  logic [33:0] drem_q;
  logic [RW-1:0] ratio_q;
  logic [4:0]  e_q;
  logic        ph_q;
  logic signed [31:0] x_q;
  logic signed [31:0] row_q [4];
  logic [1:0]  orow_q;

  // effective key count, clamped to 1..MAX_KEYS
  logic [CW-1:0] count_eff;
  always_comb begin
    if (key_count_q == 5'd0) count_eff = CW'(1);
    else if (32'(key_count_q) > 32'(MAX_KEYS)) count_eff = CW'(MAX_KEYS);
    else count_eff = CW'(key_count_q);
  end

  logic [KW-1:0] nxt;
  assign nxt = (32'(sel_q) + 32'd1 < 32'(count_q)) ? KW'(sel_q + 1'b1) : '0;

  // memory accesses
  logic key_ok;
  assign key_ok = 32'(key_index_i) < 32'(MAX_KEYS);
  logic acc;
  assign acc = start && !busy;

  always_ff @(posedge clk_i) begin
    if (acc && command_i == CMD_LOAD_TIME && key_ok)
      time_mem[KW'(key_index_i)] <= load_value_i;
    if (acc && command_i == CMD_LOAD_ELEM && key_ok)
      mat_mem[{KW'(key_index_i), element_index_i}] <= load_value_i;
    if (time_re) time_rd_q <= time_mem[time_ra];
    if (mat_re)  mat_rd_q  <= mat_mem[mat_ra];
  end

  always_comb begin
    time_re = 1'b0;
    time_ra = '0;
    mat_re  = 1'b0;
    mat_ra  = '0;
    case (state_q)
      S_SCAN: begin
        time_re = 1'b1;
        time_ra = KW'(idx_q);
      end
      S_SEG: begin
        time_re = 1'b1;
        time_ra = nxt;
      end
      S_ELEM: begin
        mat_re = 1'b1;
        mat_ra = ph_q ? {nxt, e_q[3:0]} : {sel_q, e_q[3:0]};
      end
      default: ;
    endcase
  end

  // restoring division step for the modulo
  logic [32:0] mrem;
  assign mrem = {rem_q, quo_q[31]};

  // blend: x + floor((y-x)*ratio / 2^F), saturated
  logic signed [33:0] diff;
  logic signed [RW+34:0] prod;
  logic signed [34:0] blend;
  assign diff  = 34'(signed'(mat_rd_q)) - 34'(x_q);
  assign prod  = diff * $signed({1'b0, ratio_q});
  assign blend = 35'(x_q) + 35'(prod >>> FRAC_BITS);
  logic signed [31:0] sat;
  always_comb begin
    if (blend > 35'sd2147483647) sat = 32'sh7fffffff;
    else if (blend < -35'sd2147483648) sat = 32'sh80000000;
    else sat = 32'(blend);
  end

  logic [33:0] dtry;
  assign dtry = {drem_q[32:0], 1'b0} - {1'b0, seg_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      cycle_len_q    <= CYCLE_LENGTH_RST;
      key_count_q    <= KEY_COUNT_RST;
      result_valid_o <= 1'b0;
      cnt_q <= '0;
      orow_q <= '0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == REG_CYCLE_LENGTH) cycle_len_q <= cfg_data_i;
        else key_count_q <= cfg_data_i[4:0];
      end
      unique case (state_q)
        S_IDLE: begin
          if (acc && command_i == CMD_EVAL) begin
            count_q <= count_eff;
            rem_q   <= '0;
            quo_q   <= now_time_i;
            t_q     <= now_time_i;
            cnt_q   <= '0;
            state_q <= (cycle_len_q == '0) ? S_SCAN : S_MOD;
            idx_q   <= '0;
            found_q <= 1'b0;
            stop_q  <= 1'b0;
            sel_q   <= '0;
          end
        end
        S_MOD: begin
          // shift one dividend bit a cycle; keep only the remainder
          if (mrem >= {1'b0, cycle_len_q}) rem_q <= 32'(mrem - {1'b0, cycle_len_q});
          else rem_q <= mrem[31:0];
          quo_q <= {quo_q[30:0], 1'b0};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) begin
            state_q <= S_SCAN;
            cnt_q   <= '0;
          end
        end
        S_SCAN: begin
          // read issued at idx_q; data for the previous index checked here
          if (cnt_q == 6'd0 && cycle_len_q != '0) t_q <= rem_q;
          cnt_q <= 6'd1;
          if (cnt_q != 6'd0 && !stop_q) begin
            if (t_q < time_rd_q) stop_q <= 1'b1;
            else begin
              found_q <= 1'b1;
              sel_q   <= KW'(idx_q - 1'b1);
              tsel_q  <= time_rd_q;
            end
          end
          if (cnt_q != 6'd0 && (stop_q || t_q < time_rd_q || idx_q == count_q)) begin
            state_q <= S_SEG;
            cnt_q   <= '0;
          end else if (idx_q != count_q) begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_SEG: begin
          // wait here for the read of the next key time
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd1) begin
            el_q <= {1'b0, t_q} - {1'b0, tsel_q};
            if (32'(sel_q) + 32'd1 < 32'(count_q))
              seg_q <= {1'b0, time_rd_q} - {1'b0, tsel_q};
            else
              seg_q <= {1'b0, cycle_len_q} - {1'b0, tsel_q};
            drem_q  <= '0;
            ratio_q <= '0;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt_q == 6'd0) begin
            if (!found_q || seg_q[32] || seg_q == '0 || el_q[32] || el_q == '0) begin
              ratio_q <= '0;
              state_q <= S_ELEM;
            end else if (el_q >= seg_q) begin
              ratio_q <= RW'(1) << FRAC_BITS;
              state_q <= S_ELEM;
            end else begin
              drem_q <= {1'b0, el_q};
              cnt_q  <= 6'd1;
            end
            e_q  <= '0;
            ph_q <= 1'b0;
          end else begin
            // fractional long division, one quotient bit a cycle
            if (!dtry[33]) begin
              drem_q  <= dtry;
              ratio_q <= {ratio_q[RW-2:0], 1'b1};
            end else begin
              drem_q  <= {drem_q[32:0], 1'b0};
              ratio_q <= {ratio_q[RW-2:0], 1'b0};
            end
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q == 6'(FRAC_BITS)) begin
              // hand over with a fresh count for the element phase
              state_q <= S_ELEM;
              cnt_q   <= '0;
            end
          end
          if (!found_q) sel_q <= '0;
        end
        S_ELEM: begin
          // phase 0 reads x, phase 1 reads y; the read data is registered
          ph_q <= ~ph_q;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd0) cnt_q <= 6'd1;
          if (ph_q) x_q <= mat_rd_q;
          else if (cnt_q > 6'd1) row_q[e_q[1:0] - 2'd1] <= sat;
          if (ph_q) e_q <= e_q + 5'd1;
          if (!ph_q && cnt_q > 6'd1 && e_q[1:0] == 2'd0) begin
            // a row is complete; show it
            result_valid_o <= 1'b1;
            orow_q <= 2'(e_q[3:2] - 2'd1);
          end
          if (!ph_q && e_q == 5'd16) begin
            state_q <= S_IDLE;
            cnt_q   <= '0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy        = state_q != S_IDLE;
  assign row_index_o = orow_q;
  assign last_row_o  = orow_q == 2'd3;
  assign col0_o = row_q[0];
  assign col1_o = row_q[1];
  assign col2_o = row_q[2];
  assign col3_o = row_q[3];

  a_ratio_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ELEM |-> ratio_q <= (RW'(1) << FRAC_BITS))
    else $error("ratio above one");
  a_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q) == S_ELEM)
    else $error("result outside element phase");
  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ELEM |-> 32'(sel_q) < 32'(count_q))
    else $error("selected key beyond count");

endmodule

// ===== tb/sv/tb_keyframe_matrix_interpolator.sv =====
`timescale 1ns / 100ps

module tb_keyframe_matrix_interpolator;
  import kmi_pkg::*;

  localparam int NKEYS      = 16;
  localparam int FRAC       = 16;
  // Settle time, comfortably longer than an evaluation
  localparam int SETTLE     = 160;
  localparam int STALL_MAX  = 3000;

  typedef struct {
    logic [1:0]  row;
    logic [31:0] col [4];
    logic        last;
  } row_t;

  // Matrix predictor: own copy of the key store and of the registers,
  // plus the queue of rows still to come from the block.
  class matrix_scoreboard;
    logic [31:0] key_time  [NKEYS];
    logic [31:0] key_elem  [NKEYS*16];
    logic [31:0] loop_len;
    logic [4:0]  keys_used;
    row_t        rows_due [$];
    int          errors;

    function new();
      loop_len  = CYCLE_LENGTH_RST;
      keys_used = KEY_COUNT_RST;
      errors    = 0;
      foreach (key_time[i]) key_time[i] = '0;
      foreach (key_elem[i]) key_elem[i] = '0;
    endfunction

    function void set_reg(logic idx, logic [31:0] data);
      if (idx == REG_CYCLE_LENGTH) loop_len = data;
      else keys_used = data[4:0];
    endfunction

    // Note one accepted item and queue the rows it will cause
    function void note_item(cmd_e cmd, logic [3:0] key, logic [3:0] el,
                            logic [31:0] lv, logic [31:0] now);
      int unsigned n, sel, nxt, i;
      logic [31:0] t;
      longint elapsed, seg, ratio, x, y, v;
      row_t r;
      if (cmd == CMD_LOAD_TIME) begin
        key_time[key] = lv;
        return;
      end
      if (cmd == CMD_LOAD_ELEM) begin
        key_elem[key*16 + el] = lv;
        return;
      end
      if (cmd != CMD_EVAL) return;
      n = keys_used;
      if (n < 1) n = 1;
      if (n > NKEYS) n = NKEYS;
      t = (loop_len != 0) ? now % loop_len : now;
      i = 0;
      while (i < n && !(t < key_time[i])) i++;
      sel = (i > 0) ? i - 1 : 0;
      nxt = (sel + 1 < n) ? sel + 1 : 0;
      ratio = 0;
      if (i > 0) begin
        elapsed = longint'(t) - longint'(key_time[sel]);
        if (sel + 1 < n) seg = longint'(key_time[sel+1]) - longint'(key_time[sel]);
        else seg = longint'(loop_len) - longint'(key_time[sel]);
        if (seg > 0 && elapsed > 0) begin
          if (elapsed >= seg) ratio = longint'(1) << FRAC;
          else ratio = (elapsed << FRAC) / seg;
        end
      end
      for (int rr = 0; rr < 4; rr++) begin
        r.row  = rr[1:0];
        r.last = (rr == 3);
        for (int c = 0; c < 4; c++) begin
          x = longint'($signed(key_elem[sel*16 + rr*4 + c]));
          y = longint'($signed(key_elem[nxt*16 + rr*4 + c]));
          // arithmetic shift gives the floor toward minus infinity
          v = x + (((y - x) * ratio) >>> FRAC);
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          if (v < -64'sd2147483648) v = -64'sd2147483648;
          r.col[c] = v[31:0];
        end
        rows_due.insert(rows_due.size(), r);
      end
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_row(logic [1:0] row, logic [31:0] c0, logic [31:0] c1,
                   logic [31:0] c2, logic [31:0] c3, logic last);
      row_t e;
      logic [31:0] got [4];
      if (rows_due.size() == 0) begin
        report($sformatf("row %0d with nothing expected", row));
        return;
      end
      e = rows_due.pop_front();
      got[0] = c0; got[1] = c1; got[2] = c2; got[3] = c3;
      if (row !== e.row) report($sformatf("row_index %0d, want %0d", row, e.row));
      for (int c = 0; c < 4; c++)
        if (got[c] !== e.col[c])
          report($sformatf("row %0d col%0d %h, want %h", e.row, c, got[c], e.col[c]));
      if (last !== e.last) report($sformatf("last_row %b, want %b", last, e.last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic [1:0]  command_i = CMD_NONE;
  logic [3:0]  key_index_i = '0;
  logic [3:0]  element_index_i = '0;
  logic signed [31:0] load_value_i = '0;
  logic [31:0] now_time_i = '0;
  logic        result_valid_o;
  logic [1:0]  row_index_o;
  logic signed [31:0] col0_o, col1_o, col2_o, col3_o;
  logic        last_row_o;

  matrix_scoreboard sb = new();
  bit   allow_gaps = 1'b1;
  int   stall_cycles = 0;

  always #2 clk_i = ~clk_i;

  keyframe_matrix_interpolator u_dut (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .command_i, .key_index_i, .element_index_i, .load_value_i, .now_time_i,
    .result_valid_o, .row_index_o, .col0_o, .col1_o, .col2_o, .col3_o,
    .last_row_o
  );

  // Take each row at the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check_row(row_index_o, col0_o, col1_o, col2_o, col3_o, last_row_o);
  end

  // Watchdog: count cycles in which no item and no row moves
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Issue one item; hold start high until it is accepted and leave it high,
  // so that a following item goes straight on. A gap drops start first.
  task automatic issue(cmd_e cmd, logic [3:0] key, logic [3:0] el,
                       logic [31:0] lv, logic [31:0] now);
    int gap;
    gap = 0;
    if (allow_gaps && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    command_i       <= cmd;
    key_index_i     <= key;
    element_index_i <= el;
    load_value_i    <= lv;
    now_time_i      <= now;
    do @(posedge clk_i); while (busy);
    sb.note_item(cmd, key, el, lv, now);
  endtask

  // Drop start and wait until every row is in, then let the block settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.rows_due.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write one register; drop the enable again before the next driver
  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  // Load key times: sorted across the loop by default, with a late first
  // key, duplicates or plain random order as variants. Load every key, or
  // only the keys in use once all of them hold a time.
  task automatic load_times(int layout, bit all_keys);
    logic [31:0] span, tk;
    int unsigned n, last;
    n = sb.keys_used;
    if (n < 1) n = 1;
    if (n > NKEYS) n = NKEYS;
    last = all_keys ? NKEYS : n;
    span = (sb.loop_len == 0) ? 32'hFFFF_FFFF : sb.loop_len;
    for (int k = 0; k < int'(last); k++) begin
      case (layout)
        0: tk = 32'((longint'(k) * span) / n);
        1: tk = 32'((longint'(k + 1) * span) / (n + 1));
        2: tk = 32'((longint'(k / 2) * 2 * span) / (n + 1));
        default: tk = $urandom();
      endcase
      issue(CMD_LOAD_TIME, k[3:0], 4'd0, tk, $urandom());
    end
  endtask

  function automatic logic [31:0] pick_time();
    logic [31:0] span;
    span = (sb.loop_len == 0) ? 32'hFFFF_FFFF : sb.loop_len;
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return (span < 32'h5555_5555) ? $urandom_range(0, span * 3) : $urandom();
      default: return $urandom_range(0, span - 1);
    endcase
  endfunction

  // Mostly evaluations, with element loads, odd time loads and idle commands
  task automatic random_items(int count);
    int sel;
    for (int j = 0; j < count; j++) begin
      sel = $urandom_range(0, 99);
      if (sel < 65)
        issue(CMD_EVAL, 4'($urandom()), 4'($urandom()), $urandom(), pick_time());
      else if (sel < 90)
        issue(CMD_LOAD_ELEM, 4'($urandom()), 4'($urandom()), $urandom(), $urandom());
      else if (sel < 95)
        issue(CMD_LOAD_TIME, 4'($urandom()), 4'($urandom()), $urandom(), $urandom());
      else
        issue(CMD_NONE, 4'($urandom()), 4'($urandom()), $urandom(), $urandom());
    end
  endtask

  logic [31:0] lens  [6] = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'h0004_0000,
                             32'h0010_0000, 32'h0000_0100};
  logic [31:0] counts[6] = '{32'd0, 32'd16, 32'hFFFF_FFFF, 32'd1, 32'd7, 32'd3};

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: four keys one unit apart across a four-unit loop
    write_reg(REG_CYCLE_LENGTH, 32'h0004_0000);
    write_reg(REG_KEY_COUNT, 32'd4);
    load_times(0, 1'b1);
    // Fill every element so nothing unwritten is ever read; use the extremes
    for (int k = 0; k < NKEYS; k++)
      for (int e = 0; e < 16; e++)
        issue(CMD_LOAD_ELEM, k[3:0], e[3:0],
              (e == 0) ? 32'h7FFF_FFFF : (e == 1) ? 32'h8000_0000 :
              (e == 2) ? 32'h0 : (e == 3) ? 32'hFFFF_FFFF : $urandom(), $urandom());
    issue(CMD_EVAL, 4'd0, 4'd0, 32'd0, 32'h0000_0000);   // exactly on key 0
    issue(CMD_EVAL, 4'd0, 4'd0, 32'd0, 32'h0001_0000);   // exactly on key 1
    issue(CMD_EVAL, 4'd0, 4'd0, 32'd0, 32'h0001_8000);   // half way
    issue(CMD_EVAL, 4'd0, 4'd0, 32'd0, 32'h0003_C000);   // last key, wraps to key 0
    issue(CMD_EVAL, 4'd0, 4'd0, 32'd0, 32'hFFFF_FFFF);   // largest time, reduced
    issue(CMD_NONE, 4'hF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(CMD_LOAD_TIME, 4'd0, 4'd0, 32'h0000_8000, 32'd0);
    issue(CMD_EVAL, 4'd0, 4'd0, 32'd0, 32'h0000_4000);   // before the first key
    issue(CMD_LOAD_TIME, 4'd2, 4'd0, 32'h0001_0000, 32'd0);
    issue(CMD_EVAL, 4'd0, 4'd0, 32'd0, 32'h0001_4000);   // keys 1 and 2 equal; key 2 is selected
    issue(CMD_LOAD_TIME, 4'd2, 4'd0, 32'h0000_4000, 32'd0);
    issue(CMD_EVAL, 4'd0, 4'd0, 32'd0, 32'h0001_4000);   // unsorted keys
    drain();

    // Random phases over the register extremes and several key layouts
    for (int p = 0; p < 9; p++) begin
      if (p == 8) allow_gaps = 1'b0;
      write_reg(REG_CYCLE_LENGTH, (p < 6) ? lens[p] : $urandom_range(1, 32'h0100_0000));
      write_reg(REG_KEY_COUNT, (p < 6) ? counts[5 - p] : $urandom());
      load_times(($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3), 1'b0);
      random_items(12);
      drain();
    end

    if (sb.rows_due.size() != 0) sb.report("rows still expected at the end");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
